@@ hdl/bdpa_pkg.sv @@
`default_nettype none

package bdpa_pkg;

    // Widths fixed by the patch format and the block's fields.
    localparam int SIZE_W = 63;
    localparam int LEN_W  = 31;
    localparam int WORD_W = 64;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_CTRL  = 2'd0,
        PH_DIFF  = 2'd1,
        PH_EXTRA = 2'd2,
        PH_HALT  = 2'd3
    } phase_t;

    // Result status codes.
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Place of each control word inside a triple.
    localparam logic [1:0] WD_DIFF  = 2'd0;
    localparam logic [1:0] WD_EXTRA = 2'd1;
    localparam logic [1:0] WD_SEEK  = 2'd2;

    typedef struct packed {
        logic              byte_valid;
        logic [7:0]        new_byte;
        logic [WORD_W-1:0] old_position;
        logic [1:0]        status;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/binary_delta_patch_applier.sv @@
// Channel | Signals                                   | Beat taken when
// --------+-------------------------------------------+------------------------
// in      | in_valid, in_ready, patch_byte, old_byte  | in_valid && in_ready
// out     | out_valid, out_ready, byte_valid,         | out_valid && out_ready
//         | new_byte, old_position, status            |
// cfg     | cfg_valid, cfg_ready, cfg_data (new_size) | cfg_valid && cfg_ready
//
// Every input beat yields exactly one result beat; the result is registered
// in the output buffer, in its skid entry when the main entry stalls.
// A beat can be taken every cycle while the skid entry is empty: the decoder
// state updates on acceptance; the result enters a two-entry output buffer.
// When out_ready stays low, one more beat is taken into the skid entry and
// then in_ready drops until the buffer drains.
// rst_n clears all decoder state, new_size and the output buffer at once.
// cfg_ready is always high; new_size is meant to be written while idle.

`default_nettype none

module binary_delta_patch_applier
    import bdpa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         patch_byte,
    input  wire logic [7:0]         old_byte,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    byte_valid,
    output logic [7:0]              new_byte,
    output logic signed [WORD_W-1:0] old_position,
    output logic [1:0]              status,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [SIZE_W-1:0]  cfg_data
);

    logic [SIZE_W-1:0] new_size_reg;
    logic              in_fire;
    result_t           core_res;
    result_t           out_res;

    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Length of the image to produce. Reset leaves it at zero, so an
    // unconfigured block reports completion on its first beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            new_size_reg <= '0;
        else if (cfg_valid && cfg_ready)
            new_size_reg <= cfg_data;
    end

    // Control-word decoding, diff/extra byte generation and the size checks.
    bdpa_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .patch_byte (patch_byte),
        .old_byte   (old_byte),
        .new_size   (new_size_reg),
        .res        (core_res)
    );

    // Result register with a skid entry so that input and output stall apart.
    bdpa_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_res    (core_res),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign byte_valid   = out_res.byte_valid;
    assign new_byte     = out_res.new_byte;
    assign old_position = $signed(out_res.old_position);
    assign status       = out_res.status;

endmodule

`default_nettype wire

@@ hdl/bdpa_core.sv @@
`default_nettype none

module bdpa_core
    import bdpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [7:0]        patch_byte,
    input  wire logic [7:0]        old_byte,
    input  wire logic [SIZE_W-1:0] new_size,
    output result_t                res
);

    phase_t              phase_reg, phase_next;
    logic [2:0]          byte_in_word_reg, byte_in_word_next;
    logic [1:0]          word_in_triple_reg, word_in_triple_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [LEN_W-1:0]    diff_rem_reg, diff_rem_next;
    logic [LEN_W-1:0]    extra_rem_reg, extra_rem_next;
    logic [WORD_W-1:0]   seek_reg, seek_next;
    logic [SIZE_W-1:0]   produced_reg, produced_next;
    logic [WORD_W-1:0]   old_reg, old_next;
    logic                bad_reg, bad_next;
    // Running sums for the size check, built one add per word.
    logic [SIZE_W:0]     sum_d_reg, sum_d_next;
    logic [SIZE_W+1:0]   sum_de_reg, sum_de_next;

    logic [WORD_W-1:0]   full_word;
    logic [SIZE_W-1:0]   mag;
    logic                neg;
    logic                word_last;
    logic                len_bad;
    logic [LEN_W-1:0]    len_val;
    logic [WORD_W-1:0]   seek_val;
    logic                done_now;
    logic [SIZE_W-1:0]   prod_inc;
    logic                done_inc;
    logic [LEN_W-1:0]    diff_dec;
    logic [LEN_W-1:0]    extra_dec;
    logic                triple_end;
    logic                triple_fail;

    // Control words arrive least significant byte first, so a right shift
    // leaves the finished word in place after the eighth byte.
    assign full_word   = {patch_byte, acc_reg[WORD_W-1:8]};
    assign mag         = full_word[SIZE_W-1:0];
    assign neg         = full_word[WORD_W-1];
    assign word_last   = (byte_in_word_reg == 3'd7);
    assign len_bad     = (neg && (mag != '0)) || (mag[SIZE_W-1:LEN_W] != '0);
    assign len_val     = mag[LEN_W-1:0];
    assign seek_val    = neg ? (WORD_W'(0) - {1'b0, mag}) : {1'b0, mag};
    assign done_now    = (produced_reg >= new_size);
    assign prod_inc    = produced_reg + SIZE_W'(1);
    assign done_inc    = (prod_inc >= new_size);
    assign diff_dec    = diff_rem_reg - LEN_W'(1);
    assign extra_dec   = extra_rem_reg - LEN_W'(1);
    assign triple_end  = word_last && (word_in_triple_reg != WD_DIFF)
                         && (word_in_triple_reg != WD_EXTRA);
    assign triple_fail = bad_reg
                         || (sum_d_reg > {1'b0, new_size})
                         || (sum_de_reg > {2'b00, new_size});

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_CTRL:
            begin
                if (done_now)
                begin
                    phase_next = PH_HALT;
                end
                else if (triple_end)
                begin
                    if (triple_fail)
                        phase_next = PH_HALT;
                    else if (diff_rem_reg != '0)
                        phase_next = PH_DIFF;
                    else if (extra_rem_reg != '0)
                        phase_next = PH_EXTRA;
                end
            end
            PH_DIFF:
            begin
                if (diff_dec == '0)
                begin
                    if (extra_rem_reg != '0)
                        phase_next = PH_EXTRA;
                    else if (done_inc)
                        phase_next = PH_HALT;
                    else
                        phase_next = PH_CTRL;
                end
            end
            PH_EXTRA:
            begin
                if (extra_dec == '0)
                    phase_next = done_inc ? PH_HALT : PH_CTRL;
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase
    end

    // Datapath and result.
    always_comb
    begin
        byte_in_word_next   = byte_in_word_reg;
        word_in_triple_next = word_in_triple_reg;
        acc_next            = acc_reg;
        diff_rem_next       = diff_rem_reg;
        extra_rem_next      = extra_rem_reg;
        seek_next           = seek_reg;
        produced_next       = produced_reg;
        old_next            = old_reg;
        bad_next            = bad_reg;
        sum_d_next          = sum_d_reg;
        sum_de_next         = sum_de_reg;
        res.byte_valid      = 1'b0;
        res.new_byte        = 8'd0;
        res.status          = ST_RUN;

        case (phase_reg)
            PH_CTRL:
            begin
                if (done_now)
                begin
                    res.status = ST_DONE;
                end
                else
                begin
                    acc_next          = full_word;
                    byte_in_word_next = byte_in_word_reg + 3'd1;
                    if (word_last)
                    begin
                        case (word_in_triple_reg)
                            WD_DIFF:
                            begin
                                diff_rem_next       = len_val;
                                sum_d_next          = {1'b0, produced_reg}
                                                      + (SIZE_W+1)'(len_val);
                                bad_next            = bad_reg | len_bad;
                                word_in_triple_next = WD_EXTRA;
                            end
                            WD_EXTRA:
                            begin
                                extra_rem_next      = len_val;
                                sum_de_next         = {1'b0, sum_d_reg}
                                                      + (SIZE_W+2)'(len_val);
                                bad_next            = bad_reg | len_bad;
                                word_in_triple_next = WD_SEEK;
                            end
                            default:
                            begin
                                word_in_triple_next = WD_DIFF;
                                bad_next            = 1'b0;
                                seek_next           = seek_val;
                                if (triple_fail)
                                begin
                                    res.status = ST_BAD;
                                end
                                else if ((diff_rem_reg == '0) && (extra_rem_reg == '0))
                                begin
                                    // Both lengths empty: the seek lands at once.
                                    old_next  = old_reg + seek_val;
                                    seek_next = '0;
                                end
                            end
                        endcase
                    end
                end
            end
            PH_DIFF:
            begin
                res.byte_valid = 1'b1;
                res.new_byte   = patch_byte + old_byte;
                produced_next  = prod_inc;
                diff_rem_next  = diff_dec;
                old_next       = old_reg + WORD_W'(1);
                if ((diff_dec == '0) && (extra_rem_reg == '0))
                begin
                    old_next   = old_reg + seek_reg + WORD_W'(1);
                    seek_next  = '0;
                    res.status = done_inc ? ST_DONE : ST_RUN;
                end
            end
            PH_EXTRA:
            begin
                res.byte_valid = 1'b1;
                res.new_byte   = patch_byte;
                produced_next  = prod_inc;
                extra_rem_next = extra_dec;
                if (extra_dec == '0)
                begin
                    old_next   = old_reg + seek_reg;
                    seek_next  = '0;
                    res.status = done_inc ? ST_DONE : ST_RUN;
                end
            end
            default:
            begin
                res.status = done_now ? ST_DONE : ST_BAD;
            end
        endcase

        res.old_position = old_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_CTRL;
            byte_in_word_reg   <= '0;
            word_in_triple_reg <= WD_DIFF;
            acc_reg            <= '0;
            diff_rem_reg       <= '0;
            extra_rem_reg      <= '0;
            seek_reg           <= '0;
            produced_reg       <= '0;
            old_reg            <= '0;
            bad_reg            <= 1'b0;
            sum_d_reg          <= '0;
            sum_de_reg         <= '0;
        end
        else if (in_fire)
        begin
            phase_reg          <= phase_next;
            byte_in_word_reg   <= byte_in_word_next;
            word_in_triple_reg <= word_in_triple_next;
            acc_reg            <= acc_next;
            diff_rem_reg       <= diff_rem_next;
            extra_rem_reg      <= extra_rem_next;
            seek_reg           <= seek_next;
            produced_reg       <= produced_next;
            old_reg            <= old_next;
            bad_reg            <= bad_next;
            sum_d_reg          <= sum_d_next;
            sum_de_reg         <= sum_de_next;
        end
    end

    // Once halted, only reset leaves the halt phase.
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT) |=> (phase_reg == PH_HALT))
        else $error("bdpa_core: left halt phase");

    // Image bytes come only from the diff and extra phases.
    a_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res.byte_valid |-> ((phase_reg == PH_DIFF) || (phase_reg == PH_EXTRA)))
        else $error("bdpa_core: image byte outside a data phase");

    // Decoding control words never moves the produced count.
    a_ctrl_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (phase_reg == PH_CTRL)) |=> $stable(produced_reg))
        else $error("bdpa_core: produced count moved on a control byte");

endmodule

`default_nettype wire

@@ hdl/bdpa_out_buf.sv @@
`default_nettype none

module bdpa_out_buf
    import bdpa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_fire,
    input  wire result_t in_res,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    main_v_reg, main_v_next;
    logic    skid_v_reg, skid_v_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_free;

    // The skid entry catches the beat taken in the cycle the result stalls.
    assign main_free = out_ready || !main_v_reg;
    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_res   = main_reg;

    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (main_free)
        begin
            if (skid_v_reg)
            begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                main_next   = in_res;
                main_v_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next   = in_res;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid entry is only ever filled behind a held main entry.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("bdpa_out_buf: skid entry without main entry");

    // A stalled result keeps its place and its value.
    a_main_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (main_v_reg && !out_ready) |=> (main_v_reg && $stable(main_reg)))
        else $error("bdpa_out_buf: stalled result changed");

    // A beat taken while the main entry stalls must land in the skid entry.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && main_v_reg && !out_ready) |=> skid_v_reg)
        else $error("bdpa_out_buf: beat lost under stall");

endmodule

`default_nettype wire
